>>> hw/rtl/assert_macros.svh
// assertion helper macros for the anti-replay checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same edge
`define CHK_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
// assert that a implies b in the next cycle
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

>>> hw/rtl/sarc_pkg.sv
// package for the sa table anti-replay check: codes, widths, cell types
// no dependencies
`timescale 1ns / 1ps
package sarc_pkg;
    localparam int TABLE_ENTRIES_DEF = 8;
    localparam int WINDOW_MAX_DEF    = 64;
    localparam logic [10:0] ANY_SCID = 11'd1024;
    localparam logic [6:0]  ANY_VCID = 7'd64;

    typedef enum logic [1:0] {
        REQ_FRAME = 2'd0, REQ_REG = 2'd1, REQ_REM = 2'd2, REQ_BAD = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_INTERNAL = 4'd1, ST_BAD_SPI = 4'd2, ST_REPLAY = 4'd3,
        ST_MAC = 4'd4, ST_BAD_WIN = 4'd5, ST_DUP = 4'd6, ST_FULL = 4'd7,
        ST_NOT_FOUND = 4'd8
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE, S_WALK, S_EXEC, S_OUT
    } t_state;

    // token that travels down the chain of cells
    typedef struct packed {
        logic        vld;
        logic [1:0]  req;
        logic [15:0] spi;
        logic [1:0]  tfvn;
        logic [10:0] scid;
        logic [6:0]  vcid;
        logic [6:0]  win;
        logic [31:0] seq;
        logic [1:0]  prov;
        logic        hit;      // an earlier cell claimed the request
        logic        dup;      // an active entry with this spi exists
        logic        free;     // an earlier cell took a registration
        logic        ok;       // replay check passed
        logic        commit;   // claimed cell commits its window
    } t_tok;
endpackage

>>> hw/rtl/sarc_cell.sv
// one association entry of the chain; checks and updates its window, takes registrations and removals
// depends on sarc_pkg
`timescale 1ns / 1ps
module sarc_cell
    import sarc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);
    logic        r_act;
    logic [15:0] r_spi;
    logic [1:0]  r_tfvn;
    logic [10:0] r_scid;
    logic [6:0]  r_vcid;
    logic [6:0]  r_win;
    logic [31:0] r_hi;
    logic [63:0] r_bm;
    t_tok        r_tok;

    logic        spi_eq, scope_eq, mine, chk_ok, fill;
    logic [31:0] d, back;
    logic [63:0] nb;
    logic [31:0] nh;
    t_tok        n_tok;

    always_comb begin
        spi_eq   = r_act && (r_spi == i_tok.spi);
        scope_eq = (r_tfvn == i_tok.tfvn)
                && (r_scid == ANY_SCID || r_scid == i_tok.scid)
                && (r_vcid == ANY_VCID || r_vcid == i_tok.vcid);
        d    = i_tok.seq - r_hi;
        back = 32'd0 - d;
        nb = r_bm;
        nh = r_hi;
        chk_ok = 1'b0;
        if (r_bm == 64'd0 && r_hi == 32'd0) begin
            nb = 64'd1; nh = i_tok.seq; chk_ok = 1'b1;
        end else if (d != 32'd0 && !d[31]) begin
            nb = (d >= 32'd64) ? 64'd1 : ((r_bm << d[5:0]) | 64'd1);
            nh = i_tok.seq; chk_ok = 1'b1;
        end else if (d != 32'd0 && back < {25'd0, r_win} && !r_bm[back[5:0]]) begin
            nb = r_bm | (64'd1 << back[5:0]); chk_ok = 1'b1;
        end
        // registration fill pass: first free cell takes the entry
        fill = i_tok.vld && (i_tok.req == REQ_REG) && i_tok.commit && !i_tok.free
            && !r_act;
        n_tok = i_tok;
        mine = 1'b0;
        if (i_tok.vld) begin
            case (i_tok.req)
                REQ_FRAME: begin
                    mine = !i_tok.hit && spi_eq && scope_eq && i_tok.prov != 2'd1;
                    if (mine) begin
                        n_tok.hit = 1'b1;
                        n_tok.ok  = chk_ok;
                        n_tok.commit = chk_ok && i_tok.prov == 2'd0;
                    end
                end
                REQ_REG: begin
                    if (spi_eq) n_tok.dup = 1'b1;
                    if (fill) n_tok.free = 1'b1;
                end
                REQ_REM: begin
                    mine = !i_tok.hit && spi_eq;
                    if (mine) n_tok.hit = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_tok.vld && mine && i_tok.req == REQ_FRAME && n_tok.commit) begin
                r_bm <= nb;
                r_hi <= nh;
            end
            if (i_tok.vld && mine && i_tok.req == REQ_REM) r_act <= 1'b0;
            // registration commit happens on the second pass with dup known
            if (fill) begin
                r_act  <= 1'b1;
                r_spi  <= i_tok.spi;
                r_tfvn <= i_tok.tfvn;
                r_scid <= i_tok.scid;
                r_vcid <= i_tok.vcid;
                r_win  <= i_tok.win;
                r_hi   <= 32'd0;
                r_bm   <= 64'd0;
            end
        end
    end

    assign o_tok = r_tok;
endmodule

>>> hw/rtl/sa_table_anti_replay_check.sv
// top level: request intake, chain of association cells, result register
// depends on sarc_pkg and sarc_cell
`timescale 1ns / 1ps
// usage
//   input channel i_valid/o_ready carries one request per transaction:
//   frame processing, association register or association remove
//   output channel o_valid/i_ready returns one result per request
//   a request walks a chain of TABLE_ENTRIES cells, one cell per cycle;
//   a registration walks the chain twice (duplicate scan, then slot fill)
//   one request at a time: a new transaction is taken only when the
//   block is idle again, after the previous result has been taken
//   the walk length is set by the chain depth
//   reset clears every entry's active bit, the count and both totals
//   when the receiver stalls the result is held in the output register
//   and no new request is accepted until it is taken
module sa_table_anti_replay_check
    import sarc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int WINDOW_MAX    = WINDOW_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_req_type,
    input  logic [15:0] i_spi,
    input  logic [1:0]  i_tfvn,
    input  logic [10:0] i_scid,
    input  logic [6:0]  i_vcid,
    input  logic [6:0]  i_window_size,
    input  logic [31:0] i_seq_num,
    input  logic [1:0]  i_provider_status,
    input  logic [15:0] i_header_size,
    input  logic [15:0] i_trailer_size,
    input  logic [15:0] i_payload_len,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_status,
    output logic [15:0] o_return_offset,
    output logic [15:0] o_return_size,
    output logic [3:0]  o_sa_count,
    output logic [31:0] o_accepted_total,
    output logic [31:0] o_rejected_total
);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    t_state r_state, n_state;
    t_tok   chain [TABLE_ENTRIES+1];
    t_tok   tok_head;
    t_tok   r_res;          // token latched at the chain end
    logic   r_pass2;
    logic [CW-1:0] r_cnt;
    logic [15:0] r_hs, r_ts, r_pl;
    logic [6:0]  r_cnt_act;
    logic [31:0] r_acc, r_rej;
    logic   inject, tail_vld;
    logic   bad_win, frame_ok, sizes_ok, refill;
    t_tok   r_req;

    assign o_ready = (r_state == S_IDLE);
    assign inject  = (r_state == S_WALK) && (r_cnt == '0);
    assign tail_vld = chain[TABLE_ENTRIES].vld;

    // head of chain: token injected at walk start
    always_comb begin
        tok_head = r_req;
        tok_head.vld = inject;
    end
    assign chain[0] = tok_head;

    genvar g;
    generate
        for (g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
            sarc_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_tok  (chain[g]),
                .o_tok  (chain[g+1])
            );
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_WALK;
            S_WALK: if (tail_vld) n_state = S_EXEC;
            S_EXEC: n_state = refill ? S_WALK : S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // request and result bookkeeping
    assign bad_win  = (r_req.win == 7'd0) || ({25'd0, r_req.win} > WINDOW_MAX);
    assign sizes_ok = !(r_hs > r_pl) && !(r_ts > (r_pl - r_hs));
    assign frame_ok = (r_req.req == REQ_FRAME) && r_res.hit && r_res.commit && sizes_ok;
    // registration scan passed: walk again to fill a free slot
    assign refill   = (r_req.req == REQ_REG) && !r_pass2 && !bad_win && !r_res.dup;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_pass2   <= 1'b0;
            r_cnt_act <= '0;
            r_acc     <= '0;
            r_rej     <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_req.req  <= i_req_type;   r_req.spi  <= i_spi;
                    r_req.tfvn <= i_tfvn;       r_req.scid <= i_scid;
                    r_req.vcid <= i_vcid;       r_req.win  <= i_window_size;
                    r_req.seq  <= i_seq_num;    r_req.prov <= i_provider_status;
                    r_req.hit  <= 1'b0;         r_req.dup  <= 1'b0;
                    r_req.free <= 1'b0;         r_req.ok   <= 1'b0;
                    r_req.commit <= 1'b0;       r_req.vld  <= 1'b0;
                    r_hs <= i_header_size; r_ts <= i_trailer_size; r_pl <= i_payload_len;
                    r_pass2 <= 1'b0;
                    r_cnt   <= '0;
                end
                S_WALK: begin
                    r_cnt <= tail_vld ? '0 : r_cnt + 1'b1;
                    if (tail_vld) r_res <= chain[TABLE_ENTRIES];
                end
                S_EXEC: begin
                    if (refill) begin
                        // first pass done: arm the fill pass
                        r_req.commit <= 1'b1;
                        r_pass2 <= 1'b1;
                    end
                    o_valid <= !refill;
                    o_return_offset <= frame_ok ? r_hs : 16'd0;
                    o_return_size   <= frame_ok ? (r_pl - r_hs - r_ts) : 16'd0;
                    case (r_req.req)
                        REQ_FRAME: begin
                            if (r_req.prov == 2'd1)   o_status <= ST_INTERNAL;
                            else if (!r_res.hit)      o_status <= ST_BAD_SPI;
                            else if (!r_res.ok)       o_status <= ST_REPLAY;
                            else if (!r_res.commit)   o_status <= ST_MAC;
                            else if (!sizes_ok)       o_status <= ST_INTERNAL;
                            else                      o_status <= ST_OK;
                            if (frame_ok) begin
                                r_acc <= r_acc + 32'd1;
                                o_accepted_total <= r_acc + 32'd1;
                                o_rejected_total <= r_rej;
                            end else begin
                                r_rej <= r_rej + 32'd1;
                                o_rejected_total <= r_rej + 32'd1;
                                o_accepted_total <= r_acc;
                            end
                            o_sa_count <= r_cnt_act[3:0];
                        end
                        REQ_REG: begin
                            if (bad_win)            o_status <= ST_BAD_WIN;
                            else if (r_res.dup)     o_status <= ST_DUP;
                            else if (!r_pass2)      o_status <= ST_OK;
                            else if (!r_res.free)   o_status <= ST_FULL;
                            else                    o_status <= ST_OK;
                            if (r_pass2 && r_res.free) begin
                                r_cnt_act <= r_cnt_act + 7'd1;
                                o_sa_count <= 4'(r_cnt_act + 7'd1);
                            end else o_sa_count <= r_cnt_act[3:0];
                            o_accepted_total <= r_acc;
                            o_rejected_total <= r_rej;
                        end
                        REQ_REM: begin
                            o_status <= r_res.hit ? ST_OK : ST_NOT_FOUND;
                            if (r_res.hit) begin
                                r_cnt_act <= r_cnt_act - 7'd1;
                                o_sa_count <= 4'(r_cnt_act - 7'd1);
                            end else o_sa_count <= r_cnt_act[3:0];
                            o_accepted_total <= r_acc;
                            o_rejected_total <= r_rej;
                        end
                        default: begin
                            o_status <= ST_INTERNAL;
                            o_sa_count <= r_cnt_act[3:0];
                            o_accepted_total <= r_acc;
                            o_rejected_total <= r_rej;
                        end
                    endcase
                end
                S_OUT: if (i_ready) o_valid <= 1'b0;
                default: ;
            endcase
        end
    end
endmodule

>>> hw/rtl/sarc_checker.sv
// port-level checker for the anti-replay block, bound to the top level
// depends on assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module sarc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [3:0]  o_status,
    input logic [3:0]  o_sa_count
);
    // no intake while a result is pending
    `CHK_IMPL(a_busy, i_clk, i_rst_n, o_valid, !o_ready)
    // a result stays until taken
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_status))
    // intake ends the idle phase
    `CHK_NEXT(a_take, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // the reported count never exceeds eight while a result is valid
    `CHK_IMPL(a_cnt, i_clk, i_rst_n, o_valid, o_sa_count <= 4'd8)
endmodule

bind sa_table_anti_replay_check sarc_checker u_sarc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_sa_count(o_sa_count)
);

>>> bench/tb_top.sv
// self-checking bench for sa_table_anti_replay_check: directed and random requests, scoreboard
// depends on sarc_pkg and the block's rtl
`timescale 1ns / 1ps
module tb_top;
    import sarc_pkg::*;

    localparam int N_ENT = TABLE_ENTRIES_DEF;
    localparam int W_MAX = WINDOW_MAX_DEF;

    // one request as it leaves the bench
    typedef struct {
        t_req        req;
        logic [15:0] spi;
        logic [1:0]  tfvn;
        logic [10:0] scid;
        logic [6:0]  vcid;
        logic [6:0]  win;
        logic [31:0] seq;
        logic [1:0]  prov;
        logic [15:0] hs;
        logic [15:0] ts;
        logic [15:0] pl;
    } t_request;

    typedef struct {
        t_status     st;
        logic [15:0] off;
        logic [15:0] size;
        logic [3:0]  cnt;
        logic [31:0] acc;
        logic [31:0] rej;
    } t_verdict;

    int n_errors = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("tb_top: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // table shadow plus queue of expected verdicts
    class sa_scoreboard;
        bit          act [N_ENT];
        logic [15:0] e_spi [N_ENT];
        logic [1:0]  e_tfvn [N_ENT];
        logic [10:0] e_scid [N_ENT];
        logic [6:0]  e_vcid [N_ENT];
        logic [6:0]  e_win [N_ENT];
        logic [31:0] e_hi [N_ENT];
        logic [63:0] e_bm [N_ENT];
        logic [3:0]  n_act;
        logic [31:0] n_acc, n_rej;
        t_verdict    pending[$];
        int          n_accepted_frames, n_replays, n_results;

        function new();
            foreach (act[i]) act[i] = 0;
            n_act = 0; n_acc = 0; n_rej = 0;
        endfunction

        // sliding-window test; returns pass and the would-be window
        function automatic bit window_ok(int e, logic [31:0] seq,
                                         output logic [63:0] nb, output logic [31:0] nh);
            logic [31:0] d, back;
            nb = e_bm[e]; nh = e_hi[e];
            if (e_bm[e] == 0 && e_hi[e] == 0) begin
                nb = 64'd1; nh = seq; return 1;
            end
            d = seq - e_hi[e];
            if (d != 0 && !d[31]) begin
                nb = (d >= 64) ? 64'd1 : ((e_bm[e] << d) | 64'd1);
                nh = seq; return 1;
            end
            if (d == 0) return 0;
            back = -d;
            if (back >= e_win[e]) return 0;
            if (e_bm[e][back[5:0]]) return 0;
            nb = e_bm[e] | (64'd1 << back[5:0]);
            return 1;
        endfunction

        function automatic int find_spi(logic [15:0] spi);
            for (int i = 0; i < N_ENT; i++) if (act[i] && e_spi[i] == spi) return i;
            return -1;
        endfunction

        function void note_request(t_request r);
            t_verdict v;
            int e;
            logic [63:0] nb;
            logic [31:0] nh;
            bit ok;
            v.st = ST_INTERNAL; v.off = 0; v.size = 0; e = -1; ok = 0;
            case (r.req)
                REQ_FRAME: begin
                    if (r.prov != 2'd1) begin
                        for (int i = 0; i < N_ENT && e < 0; i++)
                            if (act[i] && e_spi[i] == r.spi && e_tfvn[i] == r.tfvn
                                && (e_scid[i] == ANY_SCID || e_scid[i] == r.scid)
                                && (e_vcid[i] == ANY_VCID || e_vcid[i] == r.vcid))
                                e = i;
                        if (e < 0) v.st = ST_BAD_SPI;
                        else if (!window_ok(e, r.seq, nb, nh)) begin
                            v.st = ST_REPLAY; n_replays++;
                        end else if (r.prov != 0) v.st = ST_MAC;
                        else begin
                            e_bm[e] = nb; e_hi[e] = nh;
                            if (r.hs > r.pl || r.ts > r.pl - r.hs) v.st = ST_INTERNAL;
                            else begin
                                v.st = ST_OK; v.off = r.hs;
                                v.size = r.pl - r.hs - r.ts; ok = 1;
                            end
                        end
                    end
                    if (ok) begin
                        n_acc++; n_accepted_frames++;
                    end else n_rej++;
                end
                REQ_REG: begin
                    if (r.win == 0 || r.win > W_MAX) v.st = ST_BAD_WIN;
                    else if (find_spi(r.spi) >= 0) v.st = ST_DUP;
                    else begin
                        for (int i = 0; i < N_ENT && e < 0; i++) if (!act[i]) e = i;
                        if (e < 0) v.st = ST_FULL;
                        else begin
                            act[e] = 1; e_spi[e] = r.spi; e_tfvn[e] = r.tfvn;
                            e_scid[e] = r.scid; e_vcid[e] = r.vcid; e_win[e] = r.win;
                            e_hi[e] = 0; e_bm[e] = 0; n_act++; v.st = ST_OK;
                        end
                    end
                end
                REQ_REM: begin
                    e = find_spi(r.spi);
                    if (e < 0) v.st = ST_NOT_FOUND;
                    else begin
                        act[e] = 0; n_act--; v.st = ST_OK;
                    end
                end
                default: v.st = ST_INTERNAL;
            endcase
            v.cnt = n_act; v.acc = n_acc; v.rej = n_rej;
            pending.push_back(v);
        endfunction

        task check_result(t_verdict got);
            t_verdict w;
            n_results++;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result, status", got.st, 0);
                return;
            end
            w = pending.pop_front();
            if (got.st !== w.st) report_mismatch("status", got.st, w.st);
            if (got.off !== w.off) report_mismatch("return_offset", got.off, w.off);
            if (got.size !== w.size) report_mismatch("return_size", got.size, w.size);
            if (got.cnt !== w.cnt) report_mismatch("sa_count", got.cnt, w.cnt);
            if (got.acc !== w.acc) report_mismatch("accepted_total", got.acc, w.acc);
            if (got.rej !== w.rej) report_mismatch("rejected_total", got.rej, w.rej);
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_ready;
    logic [1:0]  i_req_type = 0;
    logic [15:0] i_spi = 0;
    logic [1:0]  i_tfvn = 0;
    logic [10:0] i_scid = 0;
    logic [6:0]  i_vcid = 0;
    logic [6:0]  i_window_size = 0;
    logic [31:0] i_seq_num = 0;
    logic [1:0]  i_provider_status = 0;
    logic [15:0] i_header_size = 0;
    logic [15:0] i_trailer_size = 0;
    logic [15:0] i_payload_len = 0;
    logic        o_valid;
    logic        i_ready = 0;
    logic [3:0]  o_status;
    logic [15:0] o_return_offset;
    logic [15:0] o_return_size;
    logic [3:0]  o_sa_count;
    logic [31:0] o_accepted_total;
    logic [31:0] o_rejected_total;

    always #5 i_clk = ~i_clk;

    sa_table_anti_replay_check i_dut (.*);

    sa_scoreboard sb = new();

    // switches the two sides consult
    bit quiet_phase = 0;     // no idling near the end
    bit hold_off = 0;        // receiver long stall
    bit stim_done = 0;
    int n_sent = 0;

    // small spi pool so lookups hit; the sequence counter per spi keeps
    // frames mostly fresh or slightly reordered
    logic [15:0] spi_pool [8] = '{16'h0001, 16'h0002, 16'h0003, 16'h0004,
                                  16'h8000, 16'hFFFF, 16'h1234, 16'h0000};
    logic [31:0] seq_next [8];
    logic [1:0]  pool_tfvn [8];
    logic [10:0] pool_scid [8];
    logic [6:0]  pool_vcid [8];

    // offer one transaction and wait for its acceptance; valid stays up
    // when the next transaction follows without a gap
    task automatic send_request(t_request r);
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_req_type <= r.req; i_spi <= r.spi; i_tfvn <= r.tfvn; i_scid <= r.scid;
        i_vcid <= r.vcid; i_window_size <= r.win; i_seq_num <= r.seq;
        i_provider_status <= r.prov; i_header_size <= r.hs;
        i_trailer_size <= r.ts; i_payload_len <= r.pl;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(r);
        n_sent++;
    endtask

    function automatic t_request blank_request(t_req q, logic [15:0] spi);
        t_request r;
        r.req = q; r.spi = spi; r.tfvn = 0; r.scid = 0; r.vcid = 0; r.win = 64;
        r.seq = 0; r.prov = 0; r.hs = 4; r.ts = 4; r.pl = 32;
        return r;
    endfunction

    // frame for pool slot k with random but mostly sensible content
    function automatic t_request pool_frame(int k);
        t_request r;
        int pick;
        r = blank_request(REQ_FRAME, spi_pool[k]);
        r.tfvn = pool_tfvn[k];
        r.scid = (pool_scid[k] == ANY_SCID) ? 11'($urandom_range(0, 2047)) : pool_scid[k];
        r.vcid = (pool_vcid[k] == ANY_VCID) ? 7'($urandom_range(0, 127)) : pool_vcid[k];
        pick = $urandom_range(0, 19);
        if (pick < 11) begin
            seq_next[k] += $urandom_range(1, 3);
            r.seq = seq_next[k];
        end else if (pick < 14) r.seq = seq_next[k] - $urandom_range(0, 70);
        else if (pick < 15) begin
            seq_next[k] += $urandom_range(60, 200);
            r.seq = seq_next[k];
        end else if (pick < 16) r.seq = seq_next[k] + 32'h8000_0000;
        else if (pick < 17) r.seq = $urandom;
        else if (pick < 18) r.tfvn = r.tfvn + 2'd1;   // scope miss
        else r.seq = seq_next[k];
        pick = $urandom_range(0, 15);
        r.prov = (pick == 0) ? 2'd1 : (pick == 1) ? 2'd2 : (pick == 2) ? 2'd3 : 2'd0;
        r.pl = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 600));
        r.hs = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
        r.ts = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40));
        return r;
    endfunction

    function automatic t_request pool_register(int k);
        t_request r;
        int pick;
        r = blank_request(REQ_REG, spi_pool[k]);
        r.tfvn = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 3);
        r.scid = (pick == 0) ? ANY_SCID : 11'($urandom_range(0, 1023));
        pick = $urandom_range(0, 3);
        r.vcid = (pick == 0) ? ANY_VCID : 7'($urandom_range(0, 63));
        pick = $urandom_range(0, 9);
        r.win = (pick == 0) ? 7'($urandom_range(65, 127)) : (pick == 1) ? 7'd0 :
                7'($urandom_range(1, 64));
        pool_tfvn[k] = r.tfvn; pool_scid[k] = r.scid; pool_vcid[k] = r.vcid;
        seq_next[k] = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFF0 : 32'($urandom_range(0, 999));
        return r;
    endfunction

    // random request: mostly frames against the pool
    task automatic random_request();
        t_request r;
        int pick, k;
        pick = $urandom_range(0, 99);
        k = $urandom_range(0, 7);
        if (pick < 72) r = pool_frame(k);
        else if (pick < 84) r = pool_register(k);
        else if (pick < 92) r = blank_request(REQ_REM, spi_pool[k]);
        else if (pick < 94) begin
            r = blank_request(REQ_BAD, 16'($urandom));
            r.seq = $urandom;
        end else begin
            // noise: fields anywhere in their ranges
            r = blank_request(t_req'($urandom_range(0, 2)), 16'($urandom));
            r.tfvn = 2'($urandom); r.scid = 11'($urandom); r.vcid = 7'($urandom);
            r.win = 7'($urandom); r.seq = $urandom; r.prov = 2'($urandom);
            r.hs = 16'($urandom); r.ts = 16'($urandom); r.pl = 16'($urandom);
        end
        send_request(r);
    endtask

    // directed opening: extremes, every request type, each special case
    task automatic directed_part();
        t_request r;
        r = blank_request(REQ_REG, 16'h0001); r.win = 0; send_request(r);   // bad window
        r.win = 65; send_request(r);
        r.win = 127; send_request(r);
        r = blank_request(REQ_REM, 16'h0001); send_request(r);              // not found
        r = blank_request(REQ_FRAME, 16'h0001); send_request(r);            // no entry
        r = blank_request(REQ_REG, 16'h0001); r.win = 1; r.tfvn = 3;
        r.scid = ANY_SCID; r.vcid = ANY_VCID; send_request(r);
        r = blank_request(REQ_REG, 16'h0001); send_request(r);              // duplicate
        r = blank_request(REQ_REG, 16'hFFFF); r.win = 64; r.scid = 11'd1023;
        r.vcid = 7'd63; send_request(r);
        // frame literal wildcard values only match the wildcard scope
        r = blank_request(REQ_FRAME, 16'h0001); r.tfvn = 3; r.scid = ANY_SCID;
        r.vcid = ANY_VCID; r.seq = 32'hFFFF_FFFF; r.hs = 0; r.ts = 0; r.pl = 0;
        send_request(r);
        r.seq = 32'h0000_0000; send_request(r);                             // wraps forward
        r.seq = 32'hFFFF_FFFF; send_request(r);                             // too old, window 1
        r.seq = 32'h0000_0000; send_request(r);                             // duplicate
        r.seq = 1; r.prov = 2'd3; send_request(r);                          // provider three
        r.prov = 2'd1; send_request(r);
        r.prov = 2'd2; send_request(r);
        r.prov = 0; r.hs = 16'hFFFF; r.pl = 16'hFFFE; send_request(r);      // header too big
        r.seq = 2; r.hs = 2; r.ts = 16'hFFFF; r.pl = 16'hFFFF; send_request(r);
        r.seq = 3; r.hs = 16'h8000; r.ts = 16'h7FFF; send_request(r);
        r = blank_request(REQ_FRAME, 16'hFFFF); r.scid = 11'd1023; r.vcid = 7'd63;
        r.seq = 32'h8000_0000; send_request(r);
        r.seq = 32'h0000_0001; send_request(r);                            // half-range back
        r = blank_request(REQ_BAD, 16'hFFFF); send_request(r);
        for (int i = 0; i < N_ENT; i++) begin
            r = blank_request(REQ_REG, 16'(16'h0100 + i)); send_request(r);   // fill, then full
        end
        r = blank_request(REQ_REM, 16'hFFFF); send_request(r);
        r = blank_request(REQ_REM, 16'h0001); send_request(r);
        for (int i = 0; i < N_ENT; i++) begin
            r = blank_request(REQ_REM, 16'(16'h0100 + i)); send_request(r);
        end
    endtask

    // sender
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        for (int k = 0; k < 8; k++) begin
            pool_tfvn[k] = 0; pool_scid[k] = 0; pool_vcid[k] = 0; seq_next[k] = 0;
        end
        directed_part();
        for (int n = 0; n < 1150; n++) begin
            if (n == 950) quiet_phase = 1;
            random_request();
        end
        i_valid <= 0;
        stim_done = 1;
    end

    // receiver: random stalls, one long hold-off while the sender pushes on
    initial begin
        int gap;
        i_ready <= 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (n_sent >= 300 && !hold_off) begin
                hold_off = 1;
                i_ready <= 0;
                repeat (400) @(posedge i_clk);
            end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 14);
                i_ready <= 0;
                repeat (gap) @(posedge i_clk);
            end else begin
                i_ready <= 1;
                @(posedge i_clk);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_verdict got;
        if (i_rst_n && o_valid && i_ready) begin
            got.st = t_status'(o_status); got.off = o_return_offset;
            got.size = o_return_size; got.cnt = o_sa_count;
            got.acc = o_accepted_total; got.rej = o_rejected_total;
            sb.check_result(got);
        end
    end

    // drain and verdict
    initial begin
        wait (stim_done);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (2 * N_ENT + 10) @(posedge i_clk);
        $display("tb_top: %0d requests sent, %0d results checked", n_sent, sb.n_results);
        $display("tb_top: %0d frames accepted, %0d replays refused",
                 sb.n_accepted_frames, sb.n_replays);
        if (n_errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("tb_top: timeout");
        $display("tb_top: done, errors");
        $finish;
    end
endmodule
